>>> design/tmp_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the timed mix pool.
// No dependencies.
package tmp_pkg;

  localparam int unsigned TimeW      = 48;
  localparam int unsigned MaxResults = 32;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic [1:0] CmdEnqueue = 2'd0;
  localparam logic [1:0] CmdDrain   = 2'd1;
  localparam logic [1:0] CmdPurge   = 2'd2;
  localparam logic [1:0] CmdFlush   = 2'd3;

  localparam logic [1:0] KindSent    = 2'd0;
  localparam logic [1:0] KindAccept  = 2'd1;
  localparam logic [1:0] KindRefuse  = 2'd2;
  localparam logic [1:0] KindNothing = 2'd3;

  localparam logic CfgMixEnabled = 1'b0;
  localparam logic CfgMaxDelay   = 1'b1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [TimeW-1:0] now_ms;
    logic [23:0]      delay_ms;
    logic [7:0]       conn_id;
    logic [31:0]      circuit_num;
    logic [7:0]       cell_command;
    logic [15:0]      payload_handle;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_conn;
    logic [31:0] out_circuit;
    logic [7:0]  out_command;
    logic [15:0] out_payload;
    logic [5:0]  occupancy;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0]       conn;
    logic [31:0]      circuit;
    logic [7:0]       command;
    logic [15:0]      payload;
    logic [TimeW-1:0] due_at;
  } slot_t;

endpackage

>>> design/tmp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/timed_mix_pool_unit.sv
`timescale 1ns / 1ps
// Timed mix pool: slot store in tmp_ram, valid bits in flops, one scan sequencer.
// Depends on tmp_pkg and tmp_ram.
// Each pass (init, scan, post) walks all POOL_SLOTS entries. Enqueue: one pass, or two
// when an entry is evicted (none when mixing is off); the next beat is taken once the
// result has been emitted. Purge: one pass. A stalled output holds the emit.
// Drain/flush: one count pass plus one pass and one emit per cell sent.
// Reset clears all valid bits and the count at once; no clearing pass.
module timed_mix_pool_unit
  import tmp_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  item_t       in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        out_data_o
);

  localparam int unsigned IW = $clog2(POOL_SLOTS);
  localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
  localparam int unsigned SW = $bits(slot_t);

  typedef enum logic [2:0] {
    StIdle, StDispatch, StScanInit, StScan, StPost, StEmit
  } state_e;

  typedef enum logic [1:0] {
    ModeMax, ModeMin, ModeCount, ModePurge
  } mode_e;

  state_e state_q, ret_q;
  mode_e  mode_q;

  logic            mix_en_q;
  logic [23:0]     max_delay_q;
  item_t           item_q;
  logic [POOL_SLOTS-1:0] valid_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   match_cnt_q;
  logic [5:0]      remain_q;
  logic [5:0]      occ_fin_q;
  logic            evict_q;
  logic [IW-1:0]   slot_q;
  logic [TimeW-1:0] fire_q;
  logic            found_q;
  logic [TimeW-1:0] best_t_q;
  logic [IW-1:0]   best_idx_q;
  slot_t           best_data_q;
  logic [IW-1:0]   scan_addr_q;
  logic            issuing_q;
  logic            rd_vld_q;
  logic [IW-1:0]   rd_idx_q;
  res_t            pend_q;
  res_t            out_q;
  logic            out_valid_q;

  logic [SW-1:0]   rdata;
  slot_t           rd_slot;
  logic            ram_we;
  slot_t           wr_slot;

  assign rd_slot = slot_t'(rdata);

  // first free slot
  logic          free_any;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // per-entry tests on the read beat
  logic rd_act, rd_match, rd_due, rd_sel, rd_same;
  always_comb begin
    rd_act   = rd_vld_q && valid_q[rd_idx_q];
    rd_match = (rd_slot.conn == item_q.conn_id) && (rd_slot.circuit == item_q.circuit_num);
    rd_due   = rd_slot.due_at <= item_q.now_ms;
    rd_sel   = (item_q.cmd == CmdFlush) ? rd_match : rd_due;
    rd_same  = (evict_q && rd_idx_q == slot_q) ? 1'b1 : rd_match;
  end

  // base fire time, saturated
  logic [23:0]      dcap;
  logic [TimeW:0]   tsum;
  logic [TimeW-1:0] tbase;
  assign dcap  = (item_q.delay_ms > max_delay_q) ? max_delay_q : item_q.delay_ms;
  assign tsum  = {1'b0, item_q.now_ms} + (TimeW + 1)'(dcap);
  assign tbase = tsum[TimeW] ? TimeMax : tsum[TimeW-1:0];

  // raise behind the latest entry on the circuit
  logic [TimeW-1:0] tfinal;
  always_comb begin
    tfinal = fire_q;
    if (found_q && fire_q <= best_t_q) begin
      tfinal = (best_t_q != TimeMax) ? best_t_q + TimeW'(1) : TimeMax;
    end
  end

  always_comb begin
    wr_slot.conn    = item_q.conn_id;
    wr_slot.circuit = item_q.circuit_num;
    wr_slot.command = item_q.cell_command;
    wr_slot.payload = item_q.payload_handle;
    wr_slot.due_at  = tfinal;
    ram_we = (state_q == StPost) && (mode_q == ModeMax);
  end

  logic [5:0] take_n;
  assign take_n = (7'(match_cnt_q) > 7'(MaxResults)) ? 6'(MaxResults) : 6'(match_cnt_q);

  tmp_ram #(
    .Width (SW),
    .Depth (POOL_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (SW'(wr_slot)),
    .raddr_i (scan_addr_q),
    .rdata_o (rdata)
  );

  function automatic res_t mk_res(logic [1:0] kind, logic [5:0] occ, logic lst);
    res_t r;
    r = '0;
    r.kind = kind;
    r.occupancy = occ;
    r.last = lst;
    return r;
  endfunction

  function automatic res_t mk_sent(slot_t c, logic [5:0] occ, logic lst);
    res_t r;
    r = mk_res(KindSent, occ, lst);
    r.out_conn    = c.conn;
    r.out_circuit = c.circuit;
    r.out_command = c.command;
    r.out_payload = c.payload;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StIdle;
      mode_q      <= ModeMax;
      mix_en_q    <= 1'b0;
      max_delay_q <= 24'd60000;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      issuing_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMixEnabled: mix_en_q    <= cfg_wdata_i[0];
          CfgMaxDelay:   max_delay_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == StEmit && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      rd_vld_q <= issuing_q;
      rd_idx_q <= scan_addr_q;

      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= StDispatch;
          end
        end
        StDispatch: begin
          fire_q  <= tbase;
          evict_q <= (item_q.cmd == CmdEnqueue) && mix_en_q && !free_any;
          unique case (item_q.cmd)
            CmdEnqueue: begin
              if (!mix_en_q) begin
                pend_q  <= mk_res(KindRefuse, 6'(count_q), 1'b1);
                ret_q   <= StIdle;
                state_q <= StEmit;
              end else if (free_any) begin
                slot_q  <= free_idx;
                mode_q  <= ModeMax;
                state_q <= StScanInit;
              end else begin
                mode_q  <= ModeMin;
                state_q <= StScanInit;
              end
            end
            CmdPurge: begin
              mode_q  <= ModePurge;
              state_q <= StScanInit;
            end
            default: begin
              mode_q  <= ModeCount;
              state_q <= StScanInit;
            end
          endcase
        end
        StScanInit: begin
          scan_addr_q <= '0;
          issuing_q   <= 1'b1;
          found_q     <= 1'b0;
          match_cnt_q <= '0;
          state_q     <= StScan;
        end
        StScan: begin
          if (issuing_q) begin
            if (scan_addr_q == IW'(POOL_SLOTS - 1)) begin
              issuing_q <= 1'b0;
            end else begin
              scan_addr_q <= scan_addr_q + IW'(1);
            end
          end
          if (rd_act) begin
            unique case (mode_q)
              ModeMax: begin
                if (rd_same && (!found_q || rd_slot.due_at > best_t_q)) begin
                  found_q  <= 1'b1;
                  best_t_q <= rd_slot.due_at;
                end
              end
              ModeMin: begin
                if (rd_sel && (!found_q || rd_slot.due_at < best_t_q)) begin
                  found_q     <= 1'b1;
                  best_t_q    <= rd_slot.due_at;
                  best_idx_q  <= rd_idx_q;
                  best_data_q <= rd_slot;
                end
              end
              ModeCount: begin
                if (rd_sel) begin
                  match_cnt_q <= match_cnt_q + CW'(1);
                end
              end
              ModePurge: begin
                if (rd_slot.conn == item_q.conn_id) begin
                  valid_q[rd_idx_q] <= 1'b0;
                  count_q <= count_q - CW'(1);
                end
              end
              default: ;
            endcase
          end
          if (rd_vld_q && rd_idx_q == IW'(POOL_SLOTS - 1)) begin
            state_q <= StPost;
          end
        end
        StPost: begin
          unique case (mode_q)
            ModeMax: begin
              if (!evict_q) begin
                valid_q[slot_q] <= 1'b1;
                count_q <= count_q + CW'(1);
                pend_q  <= mk_res(KindAccept, 6'(count_q) + 6'd1, 1'b1);
              end else begin
                pend_q  <= mk_res(KindAccept, 6'(count_q), 1'b1);
              end
              ret_q   <= StIdle;
              state_q <= StEmit;
            end
            ModeMin: begin
              if (evict_q) begin
                if (!found_q) begin
                  pend_q <= mk_res(KindRefuse, 6'(count_q), 1'b1);
                  ret_q  <= StIdle;
                end else begin
                  pend_q <= mk_sent(best_data_q, 6'(count_q), 1'b0);
                  slot_q <= best_idx_q;
                  mode_q <= ModeMax;
                  ret_q  <= StScanInit;
                end
              end else begin
                // drain or flush: send the earliest, drop it from the pool
                pend_q   <= mk_sent(best_data_q, occ_fin_q, remain_q == 6'd1);
                valid_q[best_idx_q] <= 1'b0;
                count_q  <= count_q - CW'(1);
                remain_q <= remain_q - 6'd1;
                ret_q    <= (remain_q == 6'd1) ? StIdle : StScanInit;
              end
              state_q <= StEmit;
            end
            ModeCount: begin
              if (take_n == 6'd0) begin
                pend_q  <= mk_res(KindNothing, 6'(count_q), 1'b1);
                ret_q   <= StIdle;
                state_q <= StEmit;
              end else begin
                remain_q  <= take_n;
                occ_fin_q <= 6'(count_q) - take_n;
                mode_q    <= ModeMin;
                state_q   <= StScanInit;
              end
            end
            default: begin
              pend_q  <= mk_res(KindNothing, 6'(count_q), 1'b1);
              ret_q   <= StIdle;
              state_q <= StEmit;
            end
          endcase
        end
        StEmit: begin
          // hold the beat until the output register frees up
          if (!out_valid_q || !out_stall_i) begin
            out_q   <= pend_q;
            state_q <= ret_q;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_tracks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(count_q))
    else $error("active count out of step with valid bits");

  a_idle_scan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (!issuing_q && !ram_we))
    else $error("scan or write active while idle");

  a_non_sent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind != KindSent) |->
      (out_q.out_conn == '0 && out_q.out_circuit == '0 && out_q.out_payload == '0))
    else $error("cell fields set on a status beat");

  a_take_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == StDispatch))
    else $error("accepted beat not dispatched");

endmodule
